// ===== src/wsts_pkg.sv =====
// ----------------------------------------------------------------------------
// wsts_pkg
// Shared types, sizes and tables of the smoothstep texture sampler: texture
// geometry, bank layout, queue word format and the smoothstep lookup table.
// ----------------------------------------------------------------------------
`default_nettype none

package wsts_pkg;

  // texture geometry, power-of-two sizes of at least 4 texels per axis
  localparam int TEX_W_BITS = 8;
  localparam int TEX_H_BITS = 8;
  localparam int TEX_WIDTH  = 1 << TEX_W_BITS;
  localparam int TEX_HEIGHT = 1 << TEX_H_BITS;

  // coordinate format
  localparam int COORD_W   = 24;
  localparam int FRAC_BITS = 8;

  // four banks by column and row parity, one texel of each quad per bank
  localparam int NUM_BANKS   = 4;
  localparam int BANK_SEL_W  = 2;
  localparam int BANK_COL_W  = TEX_W_BITS - 1;
  localparam int BANK_ROW_W  = TEX_H_BITS - 1;
  localparam int BANK_AW     = BANK_COL_W + BANK_ROW_W;
  localparam int BANK_DEPTH  = 1 << BANK_AW;

  // arithmetic widths
  localparam int SS_W     = 25;                 // smoothstep weight, Q0.24 up to 1.0
  localparam int WGT_W    = 2 * SS_W - 1;       // product of two weights, Q0.48 up to 1.0
  localparam int PROD_W   = WGT_W + 8;          // weight times texel
  localparam int SUM_W    = PROD_W + 2;         // sum of four
  localparam int DIV_SHIFT = 32;
  localparam int T_W      = 24;                 // sum >> 32 stays below 2^24
  localparam int RCP_W    = 25;
  localparam int QM_W     = T_W + RCP_W;
  localparam int Q_W      = 17;                 // quotient up to 65536
  localparam int R_W      = 25;
  localparam int H_W      = 18;

  localparam int TEX_MAX = 255;

  localparam logic [SS_W-1:0]  ONE_Q24   = SS_W'(1) << 24;
  localparam logic [SUM_W-1:0] ROUND_ADD = SUM_W'(TEX_MAX) << 31;
  // floor(2^32 / 255), quotient is exact or one low
  localparam logic [RCP_W-1:0] RECIP_255 = RCP_W'(32'h0101_0101);

  localparam logic [15:0] FOLD_RESET = 16'd62259;

  // queue depth between classifier and datapath
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  // smoothstep of (256 - f) / 256 in Q0.24, one entry per fraction
  typedef logic [255:0][SS_W-1:0] sstep_tab_t;

  function automatic sstep_tab_t build_sstep();
    sstep_tab_t tab;
    int d;
    for (int f = 0; f < 256; f++) begin
      d = 256 - f;
      tab[f] = SS_W'(d * d * (768 - 2 * d));
    end
    return tab;
  endfunction

  localparam sstep_tab_t SSTEP_TAB = build_sstep();

  // one word of the queue: a texel write or a classified sample
  typedef struct packed {
    logic                                is_wr;
    logic                                wr_ok;
    logic [BANK_SEL_W-1:0]               wr_bank;
    logic [BANK_AW-1:0]                  wr_addr;
    logic [7:0]                          wr_data;
    logic [NUM_BANKS-1:0][BANK_AW-1:0]   rd_addr;
    logic                                px;
    logic                                py;
    logic [SS_W-1:0]                     sx;
    logic [SS_W-1:0]                     sy;
  } q_entry_t;

endpackage

`default_nettype wire

// ===== src/wsts_front.sv =====
// ----------------------------------------------------------------------------
// wsts_front
// Input classifier: splits each word into a bank write or a sample with
// wrapped bank addresses and smoothstep weights, and pushes it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wsts_front (
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic                            in_req_type,
  input  wire logic [7:0]                      in_texel_col,
  input  wire logic [7:0]                      in_texel_row,
  input  wire logic [7:0]                      in_texel_value,
  input  wire logic [wsts_pkg::COORD_W-1:0]    in_coord_x,
  input  wire logic [wsts_pkg::COORD_W-1:0]    in_coord_y,
  input  wire logic                            q_ready,
  output logic                                 q_push,
  output wsts_pkg::q_entry_t                   q_entry
);

  localparam int WB = wsts_pkg::TEX_W_BITS;
  localparam int HB = wsts_pkg::TEX_H_BITS;

  logic [15:0]                        col_ext;
  logic [15:0]                        row_ext;
  logic [WB-1:0]                      ix;
  logic [WB-1:0]                      ix1;
  logic [HB-1:0]                      iy;
  logic [HB-1:0]                      iy1;
  logic [wsts_pkg::BANK_COL_W-1:0]    col_even;
  logic [wsts_pkg::BANK_COL_W-1:0]    col_odd;
  logic [wsts_pkg::BANK_ROW_W-1:0]    row_even;
  logic [wsts_pkg::BANK_ROW_W-1:0]    row_odd;

  // handshake, the queue decides
  assign in_tready = q_ready;
  assign q_push    = in_tvalid && q_ready;

  // wrapped integer parts, floor of the coordinate is its upper bits
  assign ix  = in_coord_x[wsts_pkg::FRAC_BITS +: WB];
  assign iy  = in_coord_y[wsts_pkg::FRAC_BITS +: HB];
  assign ix1 = ix + WB'(1);
  assign iy1 = iy + HB'(1);

  // the odd bank always reads at ix / 2, the even bank at the wrapped (ix + 1) / 2
  assign col_odd  = ix[WB-1:1];
  assign col_even = ix[0] ? ix1[WB-1:1] : ix[WB-1:1];
  assign row_odd  = iy[HB-1:1];
  assign row_even = iy[0] ? iy1[HB-1:1] : iy[HB-1:1];

  assign col_ext = {8'd0, in_texel_col};
  assign row_ext = {8'd0, in_texel_row};

  // build the queue word
  always_comb begin
    q_entry         = '0;
    q_entry.is_wr   = !in_req_type;
    q_entry.wr_ok   = (col_ext < 16'(wsts_pkg::TEX_WIDTH)) &&
                      (row_ext < 16'(wsts_pkg::TEX_HEIGHT));
    q_entry.wr_bank = {row_ext[0], col_ext[0]};
    q_entry.wr_addr = {row_ext[HB-1:1], col_ext[WB-1:1]};
    q_entry.wr_data = in_texel_value;
    for (int b = 0; b < wsts_pkg::NUM_BANKS; b++) begin
      q_entry.rd_addr[b] = {(b[1] ? row_odd : row_even), (b[0] ? col_odd : col_even)};
    end
    q_entry.px = ix[0];
    q_entry.py = iy[0];
    q_entry.sx = wsts_pkg::SSTEP_TAB[in_coord_x[wsts_pkg::FRAC_BITS-1:0]];
    q_entry.sy = wsts_pkg::SSTEP_TAB[in_coord_y[wsts_pkg::FRAC_BITS-1:0]];
  end

endmodule

`default_nettype wire

// ===== src/wsts_fifo.sv =====
// ----------------------------------------------------------------------------
// wsts_fifo
// Short queue that decouples the classifier from the texture datapath so
// each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module wsts_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire wsts_pkg::q_entry_t push_entry,
  output logic                    push_ready,
  input  wire logic               pop,
  output logic                    pop_valid,
  output wsts_pkg::q_entry_t      pop_entry
);

  wsts_pkg::q_entry_t               entries_r [wsts_pkg::Q_DEPTH];
  logic [wsts_pkg::Q_AW-1:0]        wr_ptr_r;
  logic [wsts_pkg::Q_AW-1:0]        wr_ptr_nxt;
  logic [wsts_pkg::Q_AW-1:0]        rd_ptr_r;
  logic [wsts_pkg::Q_AW-1:0]        rd_ptr_nxt;
  logic [wsts_pkg::Q_CW-1:0]        count_r;
  logic [wsts_pkg::Q_CW-1:0]        count_nxt;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = (count_r != wsts_pkg::Q_CW'(wsts_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = entries_r[rd_ptr_r];

  assign do_push = push && push_ready;
  assign do_pop  = pop && pop_valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + wsts_pkg::Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + wsts_pkg::Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + wsts_pkg::Q_CW'(do_push) - wsts_pkg::Q_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage words
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== src/wsts_back.sv =====
// ----------------------------------------------------------------------------
// wsts_back
// Texture datapath: four parity banks, weight and texel products, sum with
// rounding, division by 255, fold and saturation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wsts_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire wsts_pkg::q_entry_t q_entry,
  output logic                    q_pop,
  input  wire logic [15:0]        fold_thr,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [15:0]             out_tdata
);

  localparam int NB = wsts_pkg::NUM_BANKS;

  logic ld1, ld2, ld3, ld4, ld5, ld6;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rd_en;
  logic wr_go;

  logic [NB-1:0][7:0]                    rd_q;
  logic [wsts_pkg::SS_W-1:0]             rx;
  logic [wsts_pkg::SS_W-1:0]             ry;
  logic [wsts_pkg::WGT_W-1:0]            w1_r    [NB];
  logic [wsts_pkg::WGT_W-1:0]            w1_nxt  [NB];
  logic                                  px1_r;
  logic                                  py1_r;
  logic [wsts_pkg::PROD_W-1:0]           prod2_r   [NB];
  logic [wsts_pkg::PROD_W-1:0]           prod2_nxt [NB];
  logic [wsts_pkg::SUM_W-1:0]            sum;
  logic [wsts_pkg::T_W-1:0]              t3_r;
  logic [wsts_pkg::QM_W-1:0]             qm;
  logic [wsts_pkg::T_W-1:0]              t4_r;
  logic [wsts_pkg::Q_W-1:0]              q4_r;
  logic [wsts_pkg::R_W-1:0]              q255;
  logic [wsts_pkg::R_W-1:0]              rem;
  logic [wsts_pkg::Q_W-1:0]              q5_r;
  logic [wsts_pkg::Q_W-1:0]              q5_nxt;
  logic [wsts_pkg::H_W-1:0]              twice_thr;
  logic [wsts_pkg::H_W-1:0]              h_ext;
  logic [wsts_pkg::H_W-1:0]              h_fold;
  logic [15:0]                           h6_r;
  logic [15:0]                           h6_nxt;

  // stall chain, each stage loads when empty or when its successor moves
  assign ld6 = !v6_r || out_tready;
  assign ld5 = !v5_r || ld6;
  assign ld4 = !v4_r || ld5;
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;

  assign q_pop = q_valid && ld1;
  assign rd_en = q_pop && !q_entry.is_wr;
  assign wr_go = q_pop && q_entry.is_wr && q_entry.wr_ok;

  // texture banks, one write and one read port each
  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic [7:0] bank_mem [wsts_pkg::BANK_DEPTH];
    logic [7:0] rd_q_r;

    always_ff @(posedge clk) begin
      if (wr_go && (q_entry.wr_bank == wsts_pkg::BANK_SEL_W'(b))) begin
        bank_mem[q_entry.wr_addr] <= q_entry.wr_data;
      end
      if (rd_en) begin
        rd_q_r <= bank_mem[q_entry.rd_addr[b]];
      end
    end

    assign rd_q[b] = rd_q_r;
  end

  // corner weights: index bit 0 selects the right column, bit 1 the lower row
  assign rx = wsts_pkg::ONE_Q24 - q_entry.sx;
  assign ry = wsts_pkg::ONE_Q24 - q_entry.sy;

  always_comb begin
    w1_nxt[0] = wsts_pkg::WGT_W'(q_entry.sx) * wsts_pkg::WGT_W'(q_entry.sy);
    w1_nxt[1] = wsts_pkg::WGT_W'(rx)         * wsts_pkg::WGT_W'(q_entry.sy);
    w1_nxt[2] = wsts_pkg::WGT_W'(q_entry.sx) * wsts_pkg::WGT_W'(ry);
    w1_nxt[3] = wsts_pkg::WGT_W'(rx)         * wsts_pkg::WGT_W'(ry);
  end

  // texel of each corner from the bank of matching parity
  always_comb begin
    logic [1:0] bsel;
    for (int c = 0; c < NB; c++) begin
      bsel = {py1_r ^ c[1], px1_r ^ c[0]};
      prod2_nxt[c] = wsts_pkg::PROD_W'(w1_r[c]) * wsts_pkg::PROD_W'(rd_q[bsel]);
    end
  end

  // rounded sum, upper bits give sum / 2^32
  assign sum = wsts_pkg::SUM_W'(prod2_r[0]) + wsts_pkg::SUM_W'(prod2_r[1]) +
               wsts_pkg::SUM_W'(prod2_r[2]) + wsts_pkg::SUM_W'(prod2_r[3]) +
               wsts_pkg::ROUND_ADD;

  // reciprocal estimate of t / 255
  assign qm = wsts_pkg::QM_W'(t3_r) * wsts_pkg::QM_W'(wsts_pkg::RECIP_255);

  // one correction step for the quotient
  assign q255   = (wsts_pkg::R_W'(q4_r) << 8) - wsts_pkg::R_W'(q4_r);
  assign rem    = wsts_pkg::R_W'(t4_r) - q255;
  assign q5_nxt = q4_r + wsts_pkg::Q_W'(rem >= wsts_pkg::R_W'(wsts_pkg::TEX_MAX));

  // fold above threshold, clamp at zero, saturate
  always_comb begin
    twice_thr = wsts_pkg::H_W'(fold_thr) << 1;
    h_ext     = wsts_pkg::H_W'(q5_r);
    h_fold    = h_ext;
    if (h_ext > wsts_pkg::H_W'(fold_thr)) begin
      h_fold = (h_ext > twice_thr) ? '0 : twice_thr - h_ext;
    end
    h6_nxt = (h_fold > wsts_pkg::H_W'(16'hFFFF)) ? 16'hFFFF : h_fold[15:0];
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= rd_en;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
      if (ld5) v5_r <= v4_r;
      if (ld6) v6_r <= v5_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      for (int c = 0; c < NB; c++) begin
        w1_r[c] <= w1_nxt[c];
      end
      px1_r <= q_entry.px;
      py1_r <= q_entry.py;
    end
    if (ld2 && v1_r) begin
      for (int c = 0; c < NB; c++) begin
        prod2_r[c] <= prod2_nxt[c];
      end
    end
    if (ld3 && v2_r) begin
      t3_r <= sum[wsts_pkg::DIV_SHIFT +: wsts_pkg::T_W];
    end
    if (ld4 && v3_r) begin
      t4_r <= t3_r;
      q4_r <= qm[wsts_pkg::DIV_SHIFT +: wsts_pkg::Q_W];
    end
    if (ld5 && v4_r) begin
      q5_r <= q5_nxt;
    end
    if (ld6 && v5_r) begin
      h6_r <= h6_nxt;
    end
  end

  assign out_tvalid = v6_r;
  assign out_tdata  = h6_r;

endmodule

`default_nettype wire

// ===== src/wrapped_smoothstep_texture_sampler_core.sv =====
// ----------------------------------------------------------------------------
// wrapped_smoothstep_texture_sampler_core
// Height texture sampler with wrapped smoothstep interpolation and fold.
//
// in_*  : stream of words; in_tuser = 0 writes texel_value at (col, row),
//         in_tuser = 1 samples at (coord_x, coord_y), Q.8 signed, wrapped.
// out_* : one 16-bit Q0.16 height word per sample word, none per write.
// cfg_* : write of the fold threshold, taken at once (cfg_ready is high).
// Throughput is one word per cycle unless out_tready stalls the pipeline;
// the four texels of a sample come from four parity banks, one read port
// each. From input handshake to out_tvalid a sample passes the bank read
// with weights, products, sum, reciprocal, correction and fold registers.
// A write is visible to every sample accepted after it.
// Reset clears the queue and pipeline valids and sets the threshold to
// 62259; the texture holds no defined content until written and is not
// cleared. When out_tready is low the pipeline holds, the four-word
// queue fills and in_tready then drops until the receiver takes a word.
// ----------------------------------------------------------------------------
`default_nettype none

module wrapped_smoothstep_texture_sampler_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // texel_col, texel_row, texel_value, coord_x, coord_y
  input  wire logic        in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // height
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic               q_ready;
  logic               q_push;
  wsts_pkg::q_entry_t q_in;
  logic               q_valid;
  logic               q_pop;
  wsts_pkg::q_entry_t q_out;
  logic [15:0]        fold_thr_r;
  logic [15:0]        fold_thr_nxt;

  // fold threshold register
  assign cfg_ready    = 1'b1;
  assign fold_thr_nxt = (cfg_valid && cfg_ready) ? cfg_data : fold_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_thr_r <= wsts_pkg::FOLD_RESET;
    end else begin
      fold_thr_r <= fold_thr_nxt;
    end
  end

  // classifier
  wsts_front u_front (
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_req_type    (in_tuser),
    .in_texel_col   (in_tdata[7:0]),
    .in_texel_row   (in_tdata[15:8]),
    .in_texel_value (in_tdata[23:16]),
    .in_coord_x     (in_tdata[47:24]),
    .in_coord_y     (in_tdata[71:48]),
    .q_ready        (q_ready),
    .q_push         (q_push),
    .q_entry        (q_in)
  );

  // decoupling queue
  wsts_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_out)
  );

  // texture datapath
  wsts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_out),
    .q_pop      (q_pop),
    .fold_thr   (fold_thr_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the smoothstep texture sampler. Texel writes and
// sample words go in with random gaps while the result side stalls at random.
// A local model of the texture and threshold predicts each height word, and
// every word taken from the block is compared with the oldest prediction.
// Every sample only touches texels the bench has already loaded.
// ----------------------------------------------------------------------------
module tb_top;

  typedef enum logic {REQ_WRITE = 1'b0, REQ_SAMPLE = 1'b1} req_kind_t;

  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RUN_LIMIT     = 6_000_000;
  localparam int PHASE_WORDS   = 155;
  localparam int WINDOW_MAX    = 15;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;   // texel_col, texel_row, texel_value, coord_x, coord_y
  logic        in_tuser   = 1'b0; // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // height
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data   = '0;

  wrapped_smoothstep_texture_sampler_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // shadow texture, threshold and pending height words
  logic [7:0]  tex_shadow [wsts_pkg::TEX_WIDTH*wsts_pkg::TEX_HEIGHT];
  bit          tex_loaded [wsts_pkg::TEX_WIDTH*wsts_pkg::TEX_HEIGHT];
  logic [15:0] fold_level = wsts_pkg::FOLD_RESET;
  logic [15:0] expected_heights [$];

  int err_cnt    = 0;
  int words_sent = 0;
  int tx_quiet   = 0;
  int rx_quiet   = 0;
  int rx_hold    = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  // mostly no gap, some short ones, a few long ones, and gap-free stretches
  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 2) begin
      quiet = $urandom_range(30, 120);
      return 0;
    end
    if (r < 130) return 0;
    if (r < 188) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // smoothstep of (256 - frac)/256 in Q0.24
  function automatic logic [63:0] smooth_weight(input logic [wsts_pkg::FRAC_BITS-1:0] frac);
    logic [63:0] d;
    d = 64'd256 - frac;
    return 3 * d * d * 256 - 2 * d * d * d;
  endfunction

  function automatic logic [15:0] predict_height(input logic [23:0] cx, input logic [23:0] cy);
    logic [wsts_pkg::TEX_W_BITS-1:0] ix, ix1;
    logic [wsts_pkg::TEX_H_BITS-1:0] iy, iy1;
    logic [63:0] sx, sy, rx, ry, acc, h;
    longint folded;
    ix  = cx[wsts_pkg::FRAC_BITS +: wsts_pkg::TEX_W_BITS];
    iy  = cy[wsts_pkg::FRAC_BITS +: wsts_pkg::TEX_H_BITS];
    ix1 = ix + 1'b1;
    iy1 = iy + 1'b1;
    sx  = smooth_weight(cx[wsts_pkg::FRAC_BITS-1:0]);
    sy  = smooth_weight(cy[wsts_pkg::FRAC_BITS-1:0]);
    rx  = (64'd1 << 24) - sx;
    ry  = (64'd1 << 24) - sy;
    acc = tex_shadow[{iy, ix}] * (sx * sy) + tex_shadow[{iy, ix1}] * (rx * sy)
        + tex_shadow[{iy1, ix}] * (sx * ry) + tex_shadow[{iy1, ix1}] * (rx * ry);
    h = (acc + (64'd255 << 31)) / (64'd255 << 32);
    // mirror above the threshold, never below zero
    if (h > fold_level) begin
      folded = 2 * longint'(fold_level) - longint'(h);
      if (folded < 0) folded = 0;
      h = 64'(folded);
    end
    if (h > 64'd65535) h = 64'd65535;
    return h[15:0];
  endfunction

  function automatic logic [7:0] random_texel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom);
  endfunction

  // integer part mostly inside a small window so texels get reused
  function automatic logic [23:0] random_coord();
    logic [7:0] idx, frac;
    int r;
    idx = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, WINDOW_MAX)) : 8'($urandom);
    r = $urandom_range(0, 19);
    if (r < 3) frac = 8'd0;
    else if (r < 5) frac = 8'd255;
    else frac = 8'($urandom);
    return {8'($urandom), idx, frac};
  endfunction

  // send one word and update the shadow state when it is taken
  task automatic send_word(input req_kind_t kind, input logic [71:0] word);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    if (kind == REQ_WRITE) begin
      tex_shadow[{word[15:8], word[7:0]}] = word[23:16];
      tex_loaded[{word[15:8], word[7:0]}] = 1'b1;
    end else begin
      expected_heights.push_back(predict_height(word[47:24], word[71:48]));
    end
    words_sent++;
  endtask

  task automatic load_texel(input logic [7:0] col, input logic [7:0] row, input logic [7:0] val);
    send_word(REQ_WRITE, {24'($urandom), 24'($urandom), val, row, col});
  endtask

  // load any texel of the quad that is still undefined, then sample
  task automatic sample_at(input logic [23:0] cx, input logic [23:0] cy);
    logic [7:0] c, r;
    for (int k = 0; k < 4; k++) begin
      c = cx[15:8] + 8'(k % 2);
      r = cy[15:8] + 8'(k / 2);
      if (!tex_loaded[{r, c}]) load_texel(c, r, random_texel());
    end
    send_word(REQ_SAMPLE, {cy, cx, 24'($urandom)});
  endtask

  // wait for all pending height words, then let the pipeline settle
  task automatic drain_results();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (expected_heights.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_heights.size() != 0) begin
      report_mismatch($sformatf("%0d height words never arrived", expected_heights.size()));
      expected_heights.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_fold_threshold(input logic [15:0] level);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= level;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fold_level = level;
  endtask

  // threshold from reset, fractions at both ends, wrap at texture edges
  task automatic test_reset_threshold();
    for (int k = 0; k < 4; k++) load_texel(8'(k % 2), 8'(k / 2), 8'd255);
    // full height folds down at the reset level
    sample_at(24'h000000, 24'h000000);
    sample_at(24'h000080, 24'h000040);
    load_texel(8'd0, 8'd0, 8'd0);
    load_texel(8'd1, 8'd0, 8'd128);
    load_texel(8'd0, 8'd1, 8'd1);
    sample_at(24'h000000, 24'h000000);
    sample_at(24'h0000FF, 24'h0000FF);
    sample_at(24'h000080, 24'h000080);
    sample_at(24'h000001, 24'h0000FE);
    // negative and extreme coordinates wrap around the edges
    sample_at(24'hFFFFFF, 24'hFFFF00);
    sample_at(24'h7FFFFF, 24'h800000);
    sample_at(24'h800000, 24'h7FFFFF);
    sample_at(24'h80FF80, 24'hFF00FF);
  endtask

  // threshold at both extremes: mirror of a full height, clamp at zero
  task automatic test_fold_limits();
    set_fold_threshold(16'hFFFF);
    for (int k = 0; k < 4; k++) load_texel(8'(10 + k % 2), 8'(10 + k / 2), 8'd255);
    sample_at(24'h000A00, 24'h000A00);
    sample_at(24'h000A80, 24'h000A33);
    set_fold_threshold(16'h0000);
    sample_at(24'h000A00, 24'h000A00);
    sample_at(24'h000001, 24'h000001);
    // level equal to the threshold is left alone
    for (int k = 0; k < 4; k++) load_texel(8'(20 + k % 2), 8'(20 + k / 2), 8'd0);
    sample_at(24'h001400, 24'h001480);
  endtask

  // random writes and samples under a series of thresholds
  task automatic test_random_traffic();
    logic [15:0] levels [6];
    logic [7:0]  ix, iy;
    int start, r;
    levels = '{wsts_pkg::FOLD_RESET, 16'hFFFF, 16'h0000, 16'h8000, 16'($urandom),
               16'($urandom)};
    foreach (levels[p]) begin
      set_fold_threshold(levels[p]);
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          ix = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, WINDOW_MAX)) : 8'($urandom);
          iy = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, WINDOW_MAX)) : 8'($urandom);
          load_texel(ix, iy, random_texel());
        end else if (r < 35) begin
          // bright quad to push heights over the threshold
          ix = 8'($urandom_range(0, WINDOW_MAX));
          iy = 8'($urandom_range(0, WINDOW_MAX));
          for (int k = 0; k < 4; k++)
            load_texel(ix + 8'(k % 2), iy + 8'(k / 2), 8'($urandom_range(240, 255)));
          sample_at({8'($urandom), ix, 8'($urandom)}, {8'($urandom), iy, 8'($urandom)});
        end else begin
          sample_at(random_coord(), random_coord());
        end
      end
    end
  endtask

  // result side stalls
  always @(posedge clk) begin : rx_stall
    int g;
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      g = pick_gap(rx_quiet);
      if (g == 0) begin
        out_tready <= 1'b1;
      end else begin
        rx_hold = g - 1;
        out_tready <= 1'b0;
      end
    end
  end

  // compare each height word with the oldest prediction
  always @(posedge clk) begin : height_check
    logic [15:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_heights.size() == 0) begin
        report_mismatch($sformatf("unexpected height word %0d", out_tdata));
      end else begin
        want = expected_heights.pop_front();
        if (out_tdata !== want)
          report_mismatch($sformatf("height got %0d expected %0d", out_tdata, want));
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_threshold();
    test_fold_limits();
    test_random_traffic();
    drain_results();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
